FILE: hw/rtl/tett_pkg.sv
package tett_pkg;

  localparam int TIME_W    = 32;
  localparam int IN_TAG_W  = 16;
  localparam int SLOT_W    = 5;

  localparam logic FUNC_SCHEDULE = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_PAST    = 3'd2;
  localparam logic [2:0] KIND_FIRED   = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  typedef struct packed {
    logic                func;
    logic [TIME_W-1:0]   now_time;
    logic [TIME_W-1:0]   deadline;
    logic [IN_TAG_W-1:0] tag;
  } item_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [SLOT_W-1:0]   slot;
    logic [IN_TAG_W-1:0] tag_out;
    logic                wait_valid;
    logic [TIME_W-1:0]   next_wait;
    logic                last;
  } result_t;

endpackage

FILE: hw/rtl/tett_cell.sv
module tett_cell import tett_pkg::*; #(
  parameter int TAG_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 busy_in,
  input  logic [TIME_W-1:0]    deadline_in,
  input  logic [TAG_WIDTH-1:0] tag_in,
  output logic                 busy,
  output logic [TIME_W-1:0]    deadline,
  output logic [TAG_WIDTH-1:0] tag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (shift) begin
      busy <= busy_in;
    end
  end

  // payload is only looked at while busy
  always_ff @(posedge clk) begin
    if (shift) begin
      deadline <= deadline_in;
      tag      <= tag_in;
    end
  end

endmodule

FILE: hw/rtl/tagged_event_timer_table.sv
// a schedule item first reports accept, full or past; each item then scans the
// ring, reporting every fired slot, and ends with a summary; output stalls hold
// the scan; no new item is taken before the summary (item_stall outside idle);
// the slot ring rotates one slot past the head per cycle unless the output stalls
// reset: all slots free, no clearing pass; deadline and tag storage is not reset
module tagged_event_timer_table import tett_pkg::*; #(
  parameter int SLOTS     = 32,
  parameter int TAG_WIDTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW16  = (TAG_WIDTH < IN_TAG_W) ? TAG_WIDTH : IN_TAG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCHED,
    S_SCAN,
    S_SUMMARY
  } state_t;

  state_t state;

  logic [TIME_W-1:0]    cur_now;
  logic [TIME_W-1:0]    cur_dl;
  logic [TAG_WIDTH-1:0] cur_tag;
  logic [2:0]           cur_kind;
  logic                 cur_insert;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     scan_free;
  logic                 found;
  logic                 full;
  logic                 have_wait;
  logic [TIME_W-1:0]    best;

  logic [SLOTS-1:0]     cell_busy;
  logic [TIME_W-1:0]    cell_dl  [SLOTS];
  logic [TAG_WIDTH-1:0] cell_tag [SLOTS];
  logic [SLOTS-1:0]     nb_busy;
  logic [TIME_W-1:0]    nb_dl    [SLOTS];
  logic [TAG_WIDTH-1:0] nb_tag   [SLOTS];

  logic                 step;
  logic                 shift;
  logic                 hit;
  logic                 eff_busy;
  logic [TIME_W-1:0]    eff_dl;
  logic [TAG_WIDTH-1:0] eff_tag;
  logic                 fire;
  logic                 wb_busy;
  logic [TIME_W-1:0]    wait_now;
  logic                 better;
  logic [TAG_WIDTH-1:0] new_tag;
  logic [IN_TAG_W-1:0]  head_tag16;
  logic [IN_TAG_W-1:0]  cur_tag16;
  logic [5:0]           idx6;
  logic [5:0]           free6;
  logic                 emit;
  result_t              result_next;

  assign item_stall = (state != S_IDLE);
  assign step       = !result_valid || !result_stall;
  assign shift      = (state == S_SCAN) && step;

  // ring of slots: cell 0 is the head, its processed contents go to the tail
  for (genvar i = 0; i < SLOTS; i++) begin : g_ring
    if (i == SLOTS - 1) begin : g_tail
      assign nb_busy[i] = wb_busy;
      assign nb_dl[i]   = eff_dl;
      assign nb_tag[i]  = eff_tag;
    end else begin : g_mid
      assign nb_busy[i] = cell_busy[i+1];
      assign nb_dl[i]   = cell_dl[i+1];
      assign nb_tag[i]  = cell_tag[i+1];
    end

    tett_cell #(
      .TAG_WIDTH(TAG_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (shift),
      .busy_in    (nb_busy[i]),
      .deadline_in(nb_dl[i]),
      .tag_in     (nb_tag[i]),
      .busy       (cell_busy[i]),
      .deadline   (cell_dl[i]),
      .tag        (cell_tag[i])
    );
  end

  always_comb begin
    new_tag = '0;
    new_tag[TW16-1:0] = item.tag[TW16-1:0];
  end

  // new event drops into the first free slot as it passes the head
  assign hit      = cur_insert && (scan_idx == free_idx);
  assign eff_busy = hit || cell_busy[0];
  assign eff_dl   = hit ? cur_dl : cell_dl[0];
  assign eff_tag  = hit ? cur_tag : cell_tag[0];
  assign fire     = eff_busy && (eff_dl <= cur_now);
  assign wb_busy  = eff_busy && !fire;
  assign wait_now = eff_dl - cur_now;
  assign better   = wb_busy && (!have_wait || (wait_now < best));

  always_comb begin
    head_tag16 = '0;
    head_tag16[TW16-1:0] = eff_tag[TW16-1:0];
  end

  always_comb begin
    cur_tag16 = '0;
    cur_tag16[TW16-1:0] = cur_tag[TW16-1:0];
  end

  assign idx6  = 6'(scan_idx);
  assign free6 = 6'(free_idx);

  // result produced by the current state when the output can move
  always_comb begin
    emit        = 1'b0;
    result_next = '0;
    case (state)
      S_SCHED: begin
        emit             = 1'b1;
        result_next.kind = cur_kind;
        if (cur_insert) begin
          result_next.slot    = free6[SLOT_W-1:0];
          result_next.tag_out = cur_tag16;
        end
      end
      S_SCAN: begin
        if (fire) begin
          emit                = 1'b1;
          result_next.kind    = KIND_FIRED;
          result_next.slot    = idx6[SLOT_W-1:0];
          result_next.tag_out = head_tag16;
        end
      end
      S_SUMMARY: begin
        emit                   = 1'b1;
        result_next.kind       = KIND_SUMMARY;
        result_next.wait_valid = have_wait;
        result_next.next_wait  = best;
        result_next.last       = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      free_idx     <= '0;
      full         <= 1'b0;
      cur_insert   <= 1'b0;
    end else begin
      if (step) begin
        result_valid <= emit;
        if (emit) begin
          result <= result_next;
        end
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_now    <= item.now_time;
            cur_dl     <= item.deadline;
            cur_tag    <= new_tag;
            scan_idx   <= '0;
            found      <= 1'b0;
            scan_free  <= '0;
            have_wait  <= 1'b0;
            best       <= '0;
            if (item.func == FUNC_SCHEDULE) begin
              state <= S_SCHED;
              if (full) begin
                cur_kind   <= KIND_FULL;
                cur_insert <= 1'b0;
              end else if (item.deadline < item.now_time) begin
                cur_kind   <= KIND_PAST;
                cur_insert <= 1'b0;
              end else begin
                cur_kind   <= KIND_ACCEPT;
                cur_insert <= 1'b1;
              end
            end else begin
              cur_insert <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCHED: begin
          if (step) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (step) begin
            if (better) begin
              best      <= wait_now;
              have_wait <= 1'b1;
            end
            if (!wb_busy && !found) begin
              scan_free <= scan_idx;
              found     <= 1'b1;
            end
            scan_idx <= IDX_W'(scan_idx + 1'b1);
            if (scan_idx == LAST_IDX) begin
              state <= S_SUMMARY;
            end
          end
        end
        S_SUMMARY: begin
          if (step) begin
            free_idx   <= scan_free;
            full       <= !found;
            cur_insert <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_full_means_all_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && full) |-> (&cell_busy))
    else $error("table marked full with a free slot");

  a_free_slot_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !full) |-> !cell_busy[free_idx])
    else $error("free slot pointer names a busy slot");

  a_fire_reported: assert property (@(posedge clk) disable iff (rst)
    (shift && fire) |=> (result_valid && result.kind == KIND_FIRED && !result.last))
    else $error("fired slot not reported");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (shift && scan_idx == LAST_IDX) |=> (state == S_SUMMARY))
    else $error("ring scan did not end after a full turn");

endmodule
